@@ design/mpfd_pkg.sv @@
// Shared constants, types and codes of the page frame store drawing unit.
package mpfd_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int STORE_DEPTH  = 1024;

  localparam int ADDR_W = 10;
  localparam int CRD_W  = 16;
  localparam int POS_W  = 7;
  localparam int ROW_W  = 6;
  localparam int PAGE_W = 3;
  localparam int CNT_W  = 8;

  localparam logic [2:0] ACT_PIXEL  = 3'd0;
  localparam logic [2:0] ACT_HLINE  = 3'd1;
  localparam logic [2:0] ACT_VLINE  = 3'd2;
  localparam logic [2:0] ACT_RDPIX  = 3'd3;
  localparam logic [2:0] ACT_RDBYTE = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  localparam logic [1:0] COLOR_BLACK   = 2'd0;
  localparam logic [1:0] COLOR_WHITE   = 2'd1;
  localparam logic [1:0] COLOR_INVERSE = 2'd2;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic [1:0] ROT_RESET = ROT_90;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_XFORM, ST_CLIP, ST_PREP, ST_RD, ST_MOD, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    RK_NONE, RK_DRAW, RK_RDPIX, RK_RDBYTE, RK_CLEAR
  } kind_e;

  typedef struct packed {
    logic load;
    logic xform;
    logic clip;
    logic prep;
    logic rd;
    logic modify;
    logic sweep;
    logic emit;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  last;
    logic  sweep_last;
    logic  out_full;
  } sts_t;

endpackage

@@ design/mpfd_ram.sv @@
// Generic single-port RAM with registered read data.
module mpfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ design/mpfd_ctrl.sv @@
// Controller state machine of the drawing unit.
module mpfd_ctrl import mpfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;
  logic   from_cmd_q, from_cmd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      from_cmd_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      from_cmd_q <= from_cmd_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    from_cmd_d = from_cmd_q;
    case (state_q)
      ST_CLR: begin
        if (sts_i.sweep_last) begin
          state_d    = from_cmd_q ? ST_DONE : ST_IDLE;
          from_cmd_d = 1'b0;
        end
      end
      ST_IDLE:  if (in_valid_i) state_d = ST_XFORM;
      ST_XFORM: state_d = ST_CLIP;
      ST_CLIP:  state_d = ST_PREP;
      ST_PREP: begin
        if (sts_i.kind == RK_CLEAR) begin
          state_d    = ST_CLR;
          from_cmd_d = 1'b1;
        end else if (sts_i.kind == RK_NONE) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: state_d = ST_MOD;
      ST_MOD: begin
        if (sts_i.kind != RK_DRAW || sts_i.last) state_d = ST_DONE;
        else state_d = ST_RD;
      end
      ST_DONE: if (!sts_i.out_full) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.xform  = (state_q == ST_XFORM);
    cmd_o.clip   = (state_q == ST_CLIP);
    cmd_o.prep   = (state_q == ST_PREP);
    cmd_o.rd     = (state_q == ST_RD);
    cmd_o.modify = (state_q == ST_MOD);
    cmd_o.sweep  = (state_q == ST_CLR);
    cmd_o.emit   = (state_q == ST_DONE) && !sts_i.out_full;
  end

  assign in_ready_o = (state_q == ST_IDLE);
endmodule

@@ design/mpfd_datapath.sv @@
// Datapath: coordinate mapping, clipping, byte walker, frame store and result register.
module mpfd_datapath import mpfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  rot_i,
  input  logic [2:0]  action_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] length_i,
  input  logic [1:0]  color_i,
  input  logic [9:0]  byte_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        pixel_on_o,
  output logic [7:0]  read_data_o
);
  localparam logic signed [CRD_W-1:0] WM1 = CRD_W'(PANEL_WIDTH - 1);
  localparam logic signed [CRD_W-1:0] HM1 = CRD_W'(PANEL_HEIGHT - 1);
  localparam logic signed [CRD_W-1:0] WS  = CRD_W'(PANEL_WIDTH);
  localparam logic signed [CRD_W-1:0] HS  = CRD_W'(PANEL_HEIGHT);

  // Latched item.
  logic [2:0]              act_q;
  logic signed [CRD_W-1:0] x_q, y_q, len_q;
  logic [1:0]              color_q;
  logic [ADDR_W-1:0]       bidx_q;

  // Mapped run.
  kind_e                   kind_q, kind_d;
  logic                    vert_q, vert_d;
  logic signed [CRD_W-1:0] tx_q, ty_q, tl_q, tx_d, ty_d, tl_d;

  // Clipped run.
  logic [POS_W-1:0] a_q, c_q;
  logic [CNT_W-1:0] n_q;

  // Byte walker.
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PAGE_W-1:0] page_q;
  logic [ROW_W-1:0]  ys_q, ye_q;
  logic [ADDR_W-1:0] sweep_q;

  logic       pix_q;
  logic [7:0] rd_q;
  logic       ovalid_q, opix_q;
  logic [7:0] ord_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_i;
      x_q     <= pos_x_i;
      y_q     <= pos_y_i;
      len_q   <= length_i;
      color_q <= color_i;
      bidx_q  <= byte_index_i;
    end
  end

  // Rotation mapping.
  logic signed [CRD_W-1:0] lm1, rxw, ryw, rxh, ryh, vw, vh, px, py;
  logic                    inb;

  always_comb begin
    lm1  = len_q - CRD_W'(1);
    rxw  = WM1 - x_q;
    ryw  = WM1 - y_q;
    rxh  = HM1 - x_q;
    ryh  = HM1 - y_q;
    vw   = rot_i[0] ? HS : WS;
    vh   = rot_i[0] ? WS : HS;
    inb  = !x_q[CRD_W-1] && (x_q < vw) && !y_q[CRD_W-1] && (y_q < vh);
    case (rot_i)
      ROT_90:  begin px = ryw; py = x_q; end
      ROT_180: begin px = rxw; py = ryh; end
      ROT_270: begin px = y_q; py = rxh; end
      default: begin px = x_q; py = y_q; end
    endcase
    kind_d = RK_NONE;
    vert_d = 1'b0;
    tx_d   = px;
    ty_d   = py;
    tl_d   = CRD_W'(1);
    case (act_q)
      ACT_PIXEL: kind_d = inb ? RK_DRAW : RK_NONE;
      ACT_RDPIX: kind_d = inb ? RK_RDPIX : RK_NONE;
      ACT_HLINE: begin
        kind_d = RK_DRAW;
        tl_d   = len_q;
        case (rot_i)
          ROT_90:  begin vert_d = 1'b1; tx_d = ryw; ty_d = x_q; end
          ROT_180: begin tx_d = rxw - lm1; ty_d = ryh; end
          ROT_270: begin vert_d = 1'b1; tx_d = y_q; ty_d = rxh - lm1; end
          default: begin tx_d = x_q; ty_d = y_q; end
        endcase
      end
      ACT_VLINE: begin
        kind_d = RK_DRAW;
        tl_d   = len_q;
        case (rot_i)
          ROT_90:  begin tx_d = ryw - lm1; ty_d = x_q; end
          ROT_180: begin vert_d = 1'b1; tx_d = rxw; ty_d = ryh - lm1; end
          ROT_270: begin tx_d = y_q; ty_d = rxh; end
          default: begin vert_d = 1'b1; tx_d = x_q; ty_d = y_q; end
        endcase
      end
      ACT_RDBYTE: kind_d = RK_RDBYTE;
      ACT_CLEAR:  kind_d = RK_CLEAR;
      default:    kind_d = RK_NONE;
    endcase
  end

  // Clipping along and across the run.
  logic signed [CRD_W-1:0] along, across, lim_al, lim_ac, a2, l2;
  logic signed [CRD_W:0]   sum, l3;
  logic                    clip_ok;

  always_comb begin
    along  = vert_q ? ty_q : tx_q;
    across = vert_q ? tx_q : ty_q;
    lim_al = vert_q ? HS : WS;
    lim_ac = vert_q ? WS : HS;
    a2     = along[CRD_W-1] ? '0 : along;
    l2     = along[CRD_W-1] ? (tl_q + along) : tl_q;
    sum    = {a2[CRD_W-1], a2} + {l2[CRD_W-1], l2};
    if (sum > $signed({lim_al[CRD_W-1], lim_al}))
      l3 = {lim_al[CRD_W-1], lim_al} - {a2[CRD_W-1], a2};
    else l3 = {l2[CRD_W-1], l2};
    clip_ok = !across[CRD_W-1] && (across < lim_ac) && (l3 > 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= RK_NONE;
    end else if (cmd_i.xform) begin
      kind_q <= kind_d;
    end else if (cmd_i.clip && (kind_q == RK_DRAW || kind_q == RK_RDPIX) && !clip_ok) begin
      kind_q <= RK_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.xform) begin
      vert_q <= vert_d;
      tx_q   <= tx_d;
      ty_q   <= ty_d;
      tl_q   <= tl_d;
    end
    if (cmd_i.clip) begin
      a_q <= a2[POS_W-1:0];
      c_q <= across[POS_W-1:0];
      n_q <= l3[CNT_W-1:0];
    end
  end

  // Walker start, per-byte mask and end of run.
  logic [ROW_W-1:0]  ys_d, ye_d;
  logic [POS_W-1:0]  col_d;
  logic [2:0]        lo, hi;
  logic [7:0]        mask, rdata, wdata;
  logic              full, last;

  always_comb begin
    ys_d  = vert_q ? a_q[ROW_W-1:0] : c_q[ROW_W-1:0];
    ye_d  = vert_q ? ROW_W'(a_q + POS_W'(n_q) - POS_W'(1)) : c_q[ROW_W-1:0];
    col_d = vert_q ? c_q : a_q;
    lo    = (page_q == ys_q[ROW_W-1:3]) ? ys_q[2:0] : 3'd0;
    hi    = (page_q == ye_q[ROW_W-1:3]) ? ye_q[2:0] : 3'd7;
    mask  = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    full  = (mask == 8'hFF);
    last  = vert_q ? (page_q == ye_q[ROW_W-1:3]) : (cnt_q == CNT_W'(1));
    case (color_q)
      COLOR_BLACK:   wdata = rdata & ~mask;
      COLOR_WHITE:   wdata = rdata | mask;
      COLOR_INVERSE: wdata = rdata ^ mask;
      default:       wdata = full ? 8'hFF : rdata;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      ys_q   <= ys_d;
      ye_q   <= ye_d;
      page_q <= ys_d[ROW_W-1:3];
      cnt_q  <= n_q;
      if (kind_q == RK_RDBYTE) addr_q <= bidx_q;
      else addr_q <= ADDR_W'(ys_d[ROW_W-1:3]) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(col_d);
    end else if (cmd_i.modify) begin
      addr_q <= addr_q + (vert_q ? ADDR_W'(PANEL_WIDTH) : ADDR_W'(1));
      page_q <= page_q + PAGE_W'(vert_q);
      cnt_q  <= cnt_q - CNT_W'(1);
    end
  end

  // Clearing sweep counter wraps back to zero after the last entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sweep_q + ADDR_W'(1);
    end
  end

  mpfd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sweep || (cmd_i.modify && kind_q == RK_DRAW)),
    .addr_i  (cmd_i.sweep ? sweep_q : addr_q),
    .wdata_i (cmd_i.sweep ? 8'h00 : wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= 1'b0;
      rd_q  <= 8'h00;
    end else if (cmd_i.modify) begin
      if (kind_q == RK_RDPIX) pix_q <= rdata[ys_q[2:0]];
      if (kind_q == RK_RDBYTE) rd_q <= rdata;
    end
    if (cmd_i.emit) begin
      opix_q <= pix_q;
      ord_q  <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  assign sts_o.kind       = kind_q;
  assign sts_o.last       = last;
  assign sts_o.sweep_last = (sweep_q == ADDR_W'(STORE_DEPTH - 1));
  assign sts_o.out_full   = ovalid_q && !out_ready_i;

  assign out_valid_o = ovalid_q;
  assign pixel_on_o  = opix_q;
  assign read_data_o = ord_q;
endmodule

@@ design/mono_page_framebuffer_draw_unit.sv @@
// Top level of the page-organized monochrome frame store drawing unit.
// This unit draws into a 1024-byte frame store for a 128 x 64 monochrome panel laid out in
// pages: pixel (x, y) is bit y mod 8 of byte x + (y / 8) * 128. After reset the unit first
// clears the whole store, one byte per cycle; s_tready stays low during that entire pass
// while rotation writes are taken as usual. Each item is one command (set, clear or invert a
// pixel, a horizontal or vertical line, read a pixel, read a byte, clear the store), and each
// item produces exactly one result item. Items are handled one at a time: mapping, clipping
// and address setup come first, then every touched byte takes a read state and a modify
// state on the single store port, and a done state hands the result to the output register
// once that register is free. A clear item runs the same one-byte-per-cycle clearing sweep.
// The output register lets the next item be accepted while a result waits on m_tready.
module mono_page_framebuffer_draw_unit import mpfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command items.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata from bit 0: pos_x[15:0], pos_y[31:16], length[47:32], color[49:48],
  // byte_index[59:50], zero fill[63:60].
  input  logic [63:0] s_tdata,
  // s_tuser: action[2:0].
  input  logic [2:0]  s_tuser,
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata from bit 0: pixel_on[0], read_data[8:1], zero fill[15:9].
  output logic [15:0] m_tdata,
  // Configuration port; register 0 is the rotation at byte address 0.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [1:0] rot_q;
  cmd_t       cmd;
  sts_t       sts;
  logic       pixel_on;
  logic [7:0] read_data;

  // Addresses 0 to 3 all reach the rotation register; 4 to 7 ignore writes and read zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= ROT_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      rot_q <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'h0 : {30'h0, rot_q};

  mpfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mpfd_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rot_i        (rot_q),
    .action_i     (s_tuser),
    .pos_x_i      (s_tdata[15:0]),
    .pos_y_i      (s_tdata[31:16]),
    .length_i     (s_tdata[47:32]),
    .color_i      (s_tdata[49:48]),
    .byte_index_i (s_tdata[59:50]),
    .out_valid_o  (m_tvalid),
    .out_ready_i  (m_tready),
    .pixel_on_o   (pixel_on),
    .read_data_o  (read_data)
  );

  assign m_tdata = {7'h0, read_data, pixel_on};
endmodule

@@ design/mpfd_checker.sv @@
// Port-level checker for the drawing unit, bound to the top level.
module mpfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  // Items are handled one at a time, so acceptance closes the input side.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted in back-to-back cycles");

  // A written rotation reads back.
  a_rot_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && !paddr[2]
    |=> (paddr[2] || prdata[1:0] == $past(pwdata[1:0])))
    else $error("rotation does not read back");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
endmodule

bind mono_page_framebuffer_draw_unit mpfd_checker u_mpfd_checker (.*);

@@ verif/mono_page_framebuffer_draw_unit_test.sv @@
// Self-checking testbench for the page frame store drawing unit.
module mono_page_framebuffer_draw_unit_test;
  import mpfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Unused action codes, which must leave the store alone and return zeros.
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  // Unused color code: ignored by masked writes, but whole bytes go to all ones.
  localparam logic [1:0] COLOR_SPARE = 2'd3;
  localparam logic [2:0] REG_ROTATION = 3'd0;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    logic [2:0]  action;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] length;
    logic [1:0]  color;
    logic [9:0]  byte_index;
  } command_t;

  typedef struct {
    logic       pixel_on;
    logic [7:0] read_data;
  } readback_t;

  // One row of the directed table; a typed result is used only where is_known is set.
  typedef struct {
    command_t  cmd;
    logic      is_known;
    readback_t known;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // s_tdata from bit 0: pos_x, pos_y, length, color, byte_index, zero fill.
  logic [63:0] s_tdata = '0;
  // s_tuser: action.
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // m_tdata from bit 0: pixel_on, read_data, zero fill.
  logic [15:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mono_page_framebuffer_draw_unit dut (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run-away guard, far above the slowest legal run including the reset-time clear.
  initial begin
    #100ms;
    $display("== FAIL ==");
    $finish;
  end

  // Shadow copy of the store and of the rotation register.
  logic [7:0] shadow_store [STORE_DEPTH];
  logic [1:0] shadow_rotation;
  readback_t  pending_results [$];
  directed_row_t directed [$];
  logic       failed = 1'b0;

  int sender_gap_pct = 0;
  int receiver_gap_pct = 0;
  int stall_requests = 0;

  // ------------------------------------------------------------------------
  // Predictor of the drawing unit.
  // ------------------------------------------------------------------------
  function automatic int wrap16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  function automatic void mask_write(int addr, logic [7:0] mask, logic [1:0] color);
    int a;
    a = addr & (STORE_DEPTH - 1);
    case (color)
      COLOR_WHITE:   shadow_store[a] |= mask;
      COLOR_BLACK:   shadow_store[a] &= ~mask;
      COLOR_INVERSE: shadow_store[a] ^= mask;
      default: ;
    endcase
  endfunction

  function automatic void row_run(int x, int y, int w, logic [1:0] color);
    if (y < 0 || y >= PANEL_HEIGHT) return;
    if (x < 0) begin
      w = wrap16(w + x);
      x = 0;
    end
    if (x + w > PANEL_WIDTH) w = PANEL_WIDTH - x;
    for (int i = 0; i < w; i++)
      mask_write((y / 8) * PANEL_WIDTH + x + i, 8'(1 << (y & 7)), color);
  endfunction

  // A vertical run touches a leading partial byte, whole bytes, then a trailing partial.
  function automatic void column_run(int x, int y, int h, logic [1:0] color);
    int addr;
    int lead;
    logic [7:0] mask;
    if (x < 0 || x >= PANEL_WIDTH) return;
    if (y < 0) begin
      h = wrap16(h + y);
      y = 0;
    end
    if (y + h > PANEL_HEIGHT) h = PANEL_HEIGHT - y;
    if (h <= 0) return;
    addr = (y / 8) * PANEL_WIDTH + x;
    lead = y & 7;
    if (lead != 0) begin
      lead = 8 - lead;
      mask = 8'hFF << (8 - lead);
      if (h < lead) mask &= 8'hFF >> (lead - h);
      mask_write(addr, mask, color);
      addr += PANEL_WIDTH;
    end
    if (h >= lead) begin
      h -= lead;
      while (h >= 8) begin
        if (color == COLOR_INVERSE) shadow_store[addr & (STORE_DEPTH - 1)] ^= 8'hFF;
        else shadow_store[addr & (STORE_DEPTH - 1)] = (color != COLOR_BLACK) ? 8'hFF : 8'h00;
        addr += PANEL_WIDTH;
        h -= 8;
      end
      if (h != 0) mask_write(addr, 8'hFF >> (8 - h), color);
    end
  endfunction

  // Maps a logical pixel to the physical panel; returns 0 when outside it.
  function automatic logic place_pixel(int x, int y, output int px, output int py);
    int vw;
    int vh;
    vw = shadow_rotation[0] ? PANEL_HEIGHT : PANEL_WIDTH;
    vh = shadow_rotation[0] ? PANEL_WIDTH : PANEL_HEIGHT;
    if (x < 0 || x >= vw || y < 0 || y >= vh) return 1'b0;
    case (shadow_rotation)
      ROT_90:  begin px = PANEL_WIDTH - y - 1; py = x; end
      ROT_180: begin px = PANEL_WIDTH - x - 1; py = PANEL_HEIGHT - y - 1; end
      ROT_270: begin px = y; py = PANEL_HEIGHT - x - 1; end
      default: begin px = x; py = y; end
    endcase
    return 1'b1;
  endfunction

  function automatic readback_t draw_and_read(command_t c);
    readback_t r;
    int x, y, len, px, py;
    x = wrap16(int'(c.pos_x));
    y = wrap16(int'(c.pos_y));
    len = wrap16(int'(c.length));
    r = '{1'b0, 8'h00};
    case (c.action)
      ACT_PIXEL:
        if (place_pixel(x, y, px, py))
          mask_write(px + (py / 8) * PANEL_WIDTH, 8'(1 << (py & 7)), c.color);
      ACT_HLINE:
        case (shadow_rotation)
          ROT_90:  column_run(wrap16(PANEL_WIDTH - y - 1), x, len, c.color);
          ROT_180: row_run(wrap16(wrap16(PANEL_WIDTH - x - 1) - (len - 1)),
                           wrap16(PANEL_HEIGHT - y - 1), len, c.color);
          ROT_270: column_run(y, wrap16(wrap16(PANEL_HEIGHT - x - 1) - (len - 1)),
                              len, c.color);
          default: row_run(x, y, len, c.color);
        endcase
      ACT_VLINE:
        case (shadow_rotation)
          ROT_90:  row_run(wrap16(wrap16(PANEL_WIDTH - y - 1) - (len - 1)), x, len, c.color);
          ROT_180: column_run(wrap16(PANEL_WIDTH - x - 1),
                              wrap16(wrap16(PANEL_HEIGHT - y - 1) - (len - 1)), len, c.color);
          ROT_270: row_run(y, wrap16(PANEL_HEIGHT - x - 1), len, c.color);
          default: column_run(x, y, len, c.color);
        endcase
      ACT_RDPIX:
        if (place_pixel(x, y, px, py))
          r.pixel_on = shadow_store[(px + (py / 8) * PANEL_WIDTH) & (STORE_DEPTH - 1)][py & 7];
      ACT_RDBYTE: r.read_data = shadow_store[c.byte_index];
      ACT_CLEAR:  foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      default: ;
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Result side: random back-pressure, a long hold-off on request, and checks.
  // ------------------------------------------------------------------------
  int stalls_seen = 0;
  int hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    readback_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%t: result %h arrived with none expected", $realtime, m_tdata);
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[0] !== want.pixel_on || m_tdata[8:1] !== want.read_data ||
              m_tdata[15:9] !== 7'd0) begin
            $display("%t: expected pixel_on %b read_data %h, got pixel_on %b read_data %h",
                     $realtime, want.pixel_on, want.read_data, m_tdata[0], m_tdata[8:1]);
            failed = 1'b1;
          end
        end
      end
      if (stalls_seen != stall_requests) begin
        stalls_seen = stall_requests;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= receiver_gap_pct);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Command side.
  // ------------------------------------------------------------------------
  task automatic send_command(command_t c, logic is_known, readback_t known);
    readback_t model_out;
    s_tvalid <= 1'b1;
    s_tuser <= c.action;
    s_tdata <= {4'd0, c.byte_index, c.color, c.length, c.pos_y, c.pos_x};
    do @(posedge clk_i); while (!s_tready);
    model_out = draw_and_read(c);
    pending_results.push_back(is_known ? known : model_out);
    if ($urandom_range(0, 99) < sender_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic write_rotation(logic [1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ROTATION;
    pwdata <= {$urandom()} & ~32'h3 | 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_rotation = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Every command yields a result, so an empty queue means the unit is done.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic add_row(logic [2:0] act, int x, int y, int len, logic [1:0] color,
                         int bidx, logic is_known = 1'b0, logic pix = 1'b0,
                         logic [7:0] data = 8'h00);
    directed_row_t r;
    r.cmd = '{act, 16'(x), 16'(y), 16'(len), color, 10'(bidx)};
    r.is_known = is_known;
    r.known = '{pix, data};
    directed.push_back(r);
  endtask

  // Mostly near the panel so lines and pixels land, sometimes anywhere in 16 bits.
  function automatic logic [15:0] pick_coord();
    if ($urandom_range(0, 99) < 80) return 16'($signed($urandom_range(0, 150)) - 10);
    return 16'($urandom());
  endfunction

  function automatic command_t pick_command();
    command_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) c.action = ACT_PIXEL;
    else if (r < 45) c.action = ACT_HLINE;
    else if (r < 65) c.action = ACT_VLINE;
    else if (r < 80) c.action = ACT_RDPIX;
    else if (r < 95) c.action = ACT_RDBYTE;
    else if (r < 97) c.action = ACT_CLEAR;
    else c.action = (r[0]) ? ACT_SPARE_A : ACT_SPARE_B;
    c.pos_x = pick_coord();
    c.pos_y = pick_coord();
    c.length = ($urandom_range(0, 99) < 70) ? 16'($signed($urandom_range(0, 150)) - 10)
                                             : 16'($urandom());
    c.color = 2'($urandom_range(0, 3));
    c.byte_index = 10'($urandom());
    return c;
  endfunction

  initial begin
    logic [1:0] rotation_order [6] = '{ROT_0, ROT_270, ROT_180, ROT_90, ROT_0, ROT_270};
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    shadow_rotation = ROT_RESET;

    // Directed table, run at the reset rotation of one quarter turn.
    add_row(ACT_RDPIX, 0, 0, 0, COLOR_BLACK, 0, 1'b1);
    add_row(ACT_RDBYTE, 0, 0, 0, COLOR_BLACK, 0, 1'b1);
    add_row(ACT_RDBYTE, 0, 0, 0, COLOR_BLACK, 1023, 1'b1);
    add_row(ACT_PIXEL, 0, 0, 0, COLOR_WHITE, 0);
    add_row(ACT_PIXEL, 63, 127, 0, COLOR_WHITE, 0);
    add_row(ACT_RDPIX, 0, 0, 0, COLOR_BLACK, 0);
    add_row(ACT_RDPIX, 63, 127, 0, COLOR_BLACK, 0);
    add_row(ACT_RDPIX, 64, 0, 0, COLOR_BLACK, 0, 1'b1);
    add_row(ACT_RDPIX, -1, 5, 0, COLOR_BLACK, 0, 1'b1);
    add_row(ACT_PIXEL, -32768, 32767, 0, COLOR_WHITE, 0);
    add_row(ACT_HLINE, 3, 5, 40, COLOR_WHITE, 0);
    add_row(ACT_HLINE, -10, 2, 30, COLOR_INVERSE, 0);
    add_row(ACT_HLINE, 0, 0, -5, COLOR_WHITE, 0);
    add_row(ACT_VLINE, 10, 20, 50, COLOR_WHITE, 0);
    add_row(ACT_VLINE, 5, 100, 32767, COLOR_BLACK, 0);
    add_row(ACT_VLINE, 0, 0, -32768, COLOR_WHITE, 0);
    add_row(ACT_HLINE, 1, 0, 64, COLOR_SPARE, 0);
    add_row(ACT_PIXEL, 2, 2, 0, COLOR_SPARE, 0);
    add_row(ACT_SPARE_A, 32767, -1, -1, COLOR_WHITE, 1023, 1'b1);
    add_row(ACT_SPARE_B, -32768, 0, 0, COLOR_SPARE, 0, 1'b1);
    add_row(ACT_RDBYTE, 0, 0, 0, COLOR_BLACK, 127);
    add_row(ACT_RDBYTE, 0, 0, 0, COLOR_BLACK, 896);
    add_row(ACT_CLEAR, 0, 0, 0, COLOR_BLACK, 0);
    add_row(ACT_RDBYTE, 0, 0, 0, COLOR_BLACK, 127, 1'b1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The reset rotation is rewritten once to check that the register takes its own value.
    write_rotation(ROT_RESET);
    sender_gap_pct = 34;
    receiver_gap_pct = 45;
    foreach (directed[i]) send_command(directed[i].cmd, directed[i].is_known, directed[i].known);
    drain_results();

    // Random part: gaps swap after two phases, then stop; rotation changes every phase.
    for (int p = 0; p < 6; p++) begin
      write_rotation(rotation_order[p]);
      sender_gap_pct = (p < 2) ? 34 : (p < 4) ? 45 : 0;
      receiver_gap_pct = (p < 2) ? 45 : (p < 4) ? 34 : 0;
      // A long hold on results while commands keep coming, so the unit backs up.
      if (p == 4) stall_requests++;
      for (int n = 0; n < PHASE_ITEMS; n++) send_command(pick_command(), 1'b0, '{1'b0, 8'h00});
      drain_results();
    end

    if (failed) begin
      $display("== FAIL ==");
    end else begin
      $display("== PASS ==");
    end
    $finish;
  end

endmodule
